// ===== sv/tcw_pkg.sv =====
package tcw_pkg;

  localparam int unsigned ColsDef = 80;
  localparam int unsigned RowsDef = 25;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_CLEAR,
    ST_SCROLL,
    ST_BLANK,
    ST_DONE
  } state_e;

endpackage

// ===== sv/text_console_writer_core.sv =====
// Put and unused op codes go from input accept through ST_DONE to the output register; a read goes through ST_READ.
// Clear: ST_CLEAR zeroes every cell; a put that scrolls adds ST_SCROLL for the row copy and ST_BLANK
// for the bottom-row blank, through the single write port of the cell memory.
// Throughput: one item at a time; the next item is taken once the result sits in the output register.
// Reset: cursor homes, then a clearing pass over all COLS*ROWS cells zeroes the memory with in_ready_o low.
module text_console_writer_core
  import tcw_pkg::*;
#(
  parameter int unsigned COLS = ColsDef,
  parameter int unsigned ROWS = RowsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  attr_i,
  input  logic [7:0]  ch_i,
  input  logic [10:0] cell_addr_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [10:0] cursor_pos_o,
  output logic [6:0]  cursor_col_o,
  output logic [4:0]  cursor_row_o,
  output logic        scrolled_o,
  output logic [15:0] cell_data_o
);

  localparam int unsigned CELLS = COLS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(COLS);
  localparam int unsigned RW    = $clog2(ROWS);

  localparam logic [AW-1:0] CellLast = AW'(CELLS - 1);
  localparam logic [AW-1:0] BotBase  = AW'(CELLS - COLS);
  localparam logic [AW-1:0] ColsA    = AW'(COLS);
  localparam logic [CW-1:0] ColLast  = CW'(COLS - 1);
  localparam logic [RW-1:0] RowLast  = RW'(ROWS - 1);

  state_e state_q, state_d;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic          mv_vld_q, mv_vld_d;
  logic [AW-1:0] mv_adr_q, mv_adr_d;
  logic          rd_ok_q, rd_ok_d;
  logic          scr_q, scr_d;
  logic [15:0]   dat_q, dat_d;
  logic          out_valid_q, out_valid_d;
  logic          out_load;

  logic [15:0]   mem_q [CELLS];
  logic [15:0]   rdata_q;
  logic          we;
  logic [AW-1:0] wa;
  logic [15:0]   wd;
  logic [AW-1:0] ra;

  logic          in_acc;
  logic [AW+10:0] addr_ext;
  logic [AW+10:0] pos_ext;
  logic [CW+6:0]  col_ext;
  logic [RW+4:0]  row_ext;
  logic [AW-1:0]  line_base;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign addr_ext   = {{AW{1'b0}}, cell_addr_i};
  assign line_base  = pos_q - {{(AW-CW){1'b0}}, col_q};
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d  = state_q;
    col_d    = col_q;
    row_d    = row_q;
    pos_d    = pos_q;
    ptr_d    = ptr_q;
    mv_vld_d = 1'b0;
    mv_adr_d = mv_adr_q;
    rd_ok_d  = rd_ok_q;
    scr_d    = scr_q;
    dat_d    = dat_q;
    we       = 1'b0;
    wa       = ptr_q;
    wd       = '0;
    ra       = addr_ext[AW-1:0];

    unique case (state_q)
      ST_INIT: begin
        we = 1'b1;
        if (ptr_q == CellLast) begin
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          scr_d   = 1'b0;
          dat_d   = '0;
          state_d = ST_DONE;
          case (op_i)
            OP_PUT: begin
              if (ch_i == CH_CR) begin
                col_d = '0;
                pos_d = line_base;
              end else begin
                if (ch_i != CH_LF) begin
                  we = 1'b1;
                  wa = pos_q;
                  wd = {attr_i, ch_i};
                end
                if (ch_i != CH_LF && col_q != ColLast) begin
                  col_d = col_q + 1'b1;
                  pos_d = pos_q + 1'b1;
                end else begin
                  col_d = '0;
                  if (row_q == RowLast) begin
                    pos_d   = BotBase;
                    scr_d   = 1'b1;
                    ptr_d   = ColsA;
                    state_d = ST_SCROLL;
                  end else begin
                    row_d = row_q + 1'b1;
                    pos_d = line_base + ColsA;
                  end
                end
              end
            end
            OP_CLEAR: begin
              col_d   = '0;
              row_d   = '0;
              pos_d   = '0;
              ptr_d   = '0;
              state_d = ST_CLEAR;
            end
            OP_READ: begin
              rd_ok_d = (addr_ext < (AW+11)'(CELLS));
              state_d = ST_READ;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_READ: begin
        dat_d   = rd_ok_q ? rdata_q : '0;
        state_d = ST_DONE;
      end
      ST_CLEAR: begin
        we = 1'b1;
        if (ptr_q == CellLast) begin
          state_d = ST_DONE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      ST_SCROLL: begin
        ra       = ptr_q;
        we       = mv_vld_q;
        wa       = mv_adr_q;
        wd       = rdata_q;
        mv_vld_d = 1'b1;
        mv_adr_d = ptr_q - ColsA;
        if (ptr_q == CellLast) begin
          ptr_d   = BotBase;
          state_d = ST_BLANK;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      ST_BLANK: begin
        we = 1'b1;
        if (mv_vld_q) begin
          wa = mv_adr_q;
          wd = rdata_q;
        end else if (ptr_q == CellLast) begin
          state_d = ST_DONE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      col_q       <= '0;
      row_q       <= '0;
      pos_q       <= '0;
      ptr_q       <= '0;
      mv_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      pos_q       <= pos_d;
      ptr_q       <= ptr_d;
      mv_vld_q    <= mv_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mv_adr_q <= mv_adr_d;
    rd_ok_q  <= rd_ok_d;
    scr_q    <= scr_d;
    dat_q    <= dat_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rdata_q <= mem_q[ra];
  end

  assign pos_ext = {11'b0, pos_q};
  assign col_ext = {7'b0, col_q};
  assign row_ext = {5'b0, row_q};

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      cursor_pos_o <= pos_ext[10:0];
      cursor_col_o <= col_ext[6:0];
      cursor_row_o <= row_ext[4:0];
      scrolled_o   <= scr_q;
      cell_data_o  <= dat_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (AW+RW+CW)'(pos_q) ==
      (AW+RW+CW)'(row_q) * (AW+RW+CW)'(COLS) + (AW+RW+CW)'(col_q))
    else $error("cursor position out of step with row and column");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((CW+1)'(col_q) < (CW+1)'(COLS)) && ((RW+1)'(row_q) < (RW+1)'(ROWS)))
    else $error("cursor outside the screen");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && scr_q) |-> (row_q == RowLast && col_q == '0))
    else $error("scroll left cursor off the start of the last row");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mv_vld_q |-> (state_q == ST_SCROLL || state_q == ST_BLANK))
    else $error("row copy write pending outside the scroll sweep");
`endif

endmodule
